// ===== sv/spq_pkg.sv =====
// spq_pkg: shared constants and types for the sorted priority queue.
// No dependencies; used by the interfaces and by sorted_priority_queue.
package spq_pkg;

  localparam int SPQ_DEPTH         = 16;
  localparam int SPQ_PAYLOAD_BITS  = 32;
  localparam int SPQ_PRIORITY_BITS = 16;
  localparam int SPQ_OCC_BITS      = 5;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_HEAD,
    S_EMIT
  } spq_state_t;

endpackage

// ===== sv/spq_if.sv =====
// spq_req_if / spq_rsp_if: valid-ready channels for queue requests and results.
// Depends on spq_pkg for default widths.
interface spq_req_if #(
  parameter int PAYLOAD_BITS  = spq_pkg::SPQ_PAYLOAD_BITS,
  parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS
) ();
  logic                     valid;
  logic                     ready;
  logic                     operation;
  logic [PAYLOAD_BITS-1:0]  payload;
  logic [PRIORITY_BITS-1:0] priority_req;

  modport source (output valid, output operation, output payload, output priority_req,
                  input ready);
  modport sink   (input valid, input operation, input payload, input priority_req,
                  output ready);
endinterface

interface spq_rsp_if #(
  parameter int PAYLOAD_BITS  = spq_pkg::SPQ_PAYLOAD_BITS,
  parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS,
  parameter int OCC_BITS      = spq_pkg::SPQ_OCC_BITS
) ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               status;
  logic [PAYLOAD_BITS-1:0]  payload_out;
  logic [PRIORITY_BITS-1:0] priority_out;
  logic [OCC_BITS-1:0]      occupancy;

  modport source (output valid, output status, output payload_out, output priority_out,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input payload_out, input priority_out,
                  input occupancy, output ready);
endinterface

// ===== sv/spq_ram.sv =====
// spq_ram: entry store, one write port and one read port, registered read data.
// No dependencies.
module spq_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sorted_priority_queue.sv =====
// sorted_priority_queue: stable sorted priority queue over a circular entry RAM.
// Reject or insert into empty: goes straight to S_EMIT. Remove: S_HEAD, then S_EMIT.
// Other inserts scan from the tail past every stored entry with priority strictly above the new one
// (each is read and moved up one slot, one RAM access pair per cycle).
// Next request is taken once the previous one has reached the output register.
// Synchronous active-low reset empties the queue; RAM contents are not cleared.
module sorted_priority_queue #(
  parameter int DEPTH         = spq_pkg::SPQ_DEPTH,
  parameter int PAYLOAD_BITS  = spq_pkg::SPQ_PAYLOAD_BITS,
  parameter int PRIORITY_BITS = spq_pkg::SPQ_PRIORITY_BITS
) (
  input  logic      clk,
  input  logic      rst_n,
  spq_req_if.sink   in_req,
  spq_rsp_if.source out_rsp
);
  import spq_pkg::*;

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int ENTRY_W = PAYLOAD_BITS + PRIORITY_BITS;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  spq_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [PAYLOAD_BITS-1:0]  new_pay_r;
  logic [PRIORITY_BITS-1:0] new_pri_r;
  spq_status_t              res_status_r, res_status_nxt;
  logic [PAYLOAD_BITS-1:0]  res_pay_r, res_pay_nxt;
  logic [PRIORITY_BITS-1:0] res_pri_r, res_pri_nxt;

  spq_status_t              out_status_r;
  logic [PAYLOAD_BITS-1:0]  out_pay_r;
  logic [PRIORITY_BITS-1:0] out_pri_r;
  logic [SPQ_OCC_BITS-1:0]  out_occ_r;

  logic                 accept;
  logic                 out_load;
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  logic [PRIORITY_BITS-1:0] rd_pri;
  logic [PAYLOAD_BITS-1:0]  rd_pay;
  logic [CW-1:0]            cnt_m1;
  logic [SPQ_OCC_BITS+CW-1:0] occ_wide;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [AW-1:0] ofs);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, ofs};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  spq_ram #(
    .DEPTH (DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_pri   = ram_rdata[ENTRY_W-1:PAYLOAD_BITS];
  assign rd_pay   = ram_rdata[PAYLOAD_BITS-1:0];
  assign cnt_m1   = count_r - 1'b1;
  assign accept   = in_req.valid && in_req.ready;
  assign occ_wide = {{SPQ_OCC_BITS{1'b0}}, count_r};

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_pay_nxt    = res_pay_r;
    res_pri_nxt    = res_pri_r;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    ram_we         = 1'b0;
    ram_waddr      = phys(head_r, idx_r + 1'b1);
    ram_wdata      = {new_pri_r, new_pay_r};
    ram_re         = 1'b0;
    ram_raddr      = head_r;
    in_req.ready   = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          res_pay_nxt = '0;
          res_pri_nxt = '0;
          state_nxt   = S_EMIT;
          if (in_req.operation == OP_INSERT) begin
            if (count_r == FULL_CNT) begin
              res_status_nxt = ST_FULL;
            end else if (count_r == '0) begin
              ram_we         = 1'b1;
              ram_waddr      = head_r;
              ram_wdata      = {in_req.priority_req, in_req.payload};
              count_nxt      = count_r + 1'b1;
              res_status_nxt = ST_DONE;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = phys(head_r, cnt_m1[AW-1:0]);
              idx_nxt   = cnt_m1[AW-1:0];
              state_nxt = S_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = ST_EMPTY;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_r;
              state_nxt = S_HEAD;
            end
          end
        end
      end
      S_SCAN: begin
        ram_we = 1'b1;
        if (rd_pri > new_pri_r) begin
          // move entry up one slot, keep walking toward the head
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = phys(head_r, idx_r - 1'b1);
            idx_nxt   = idx_r - 1'b1;
          end
        end else begin
          count_nxt      = count_r + 1'b1;
          res_status_nxt = ST_DONE;
          state_nxt      = S_EMIT;
        end
      end
      S_PLACE: begin
        ram_we         = 1'b1;
        ram_waddr      = head_r;
        count_nxt      = count_r + 1'b1;
        res_status_nxt = ST_DONE;
        state_nxt      = S_EMIT;
      end
      S_HEAD: begin
        res_pay_nxt    = rd_pay;
        res_pri_nxt    = rd_pri;
        res_status_nxt = ST_DONE;
        head_nxt       = phys(head_r, AW'(1));
        count_nxt      = cnt_m1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_pay_r    <= res_pay_nxt;
    res_pri_r    <= res_pri_nxt;
    if (accept) begin
      new_pay_r <= in_req.payload;
      new_pri_r <= in_req.priority_req;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_pay_r    <= res_pay_r;
      out_pri_r    <= res_pri_r;
      out_occ_r    <= occ_wide[SPQ_OCC_BITS-1:0];
    end
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.payload_out  = out_pay_r;
  assign out_rsp.priority_out = out_pri_r;
  assign out_rsp.occupancy    = out_occ_r;

endmodule
